// ----- rtl/ept_pkg.sv -----
// Shared constants, types and helper functions for the echo pulse timer.
`default_nettype none

package ept_pkg;

	// Sizing of the timer.
	localparam int CHANNELS     = 4;
	localparam int COUNT_BITS   = 16;
	localparam int REG_BITS     = 16;
	localparam int DIST_BITS    = 16;
	localparam int ECHO_BITS    = 4;
	localparam int OUT_CHANNELS = 4;
	localparam int CMP_BITS     = (COUNT_BITS > REG_BITS) ? COUNT_BITS : REG_BITS;
	localparam int CFG_IDX_BITS = 2;

	// Item opcodes.
	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_BITS-1:0] REG_START_COUNT      = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RISE_DEADLINE    = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_FALL_DEADLINE    = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT_DISTANCE = 2'd3;

	// Register values after reset.
	localparam logic [REG_BITS-1:0] START_COUNT_RST      = 16'd60000;
	localparam logic [REG_BITS-1:0] RISE_DEADLINE_RST    = 16'd54000;
	localparam logic [REG_BITS-1:0] FALL_DEADLINE_RST    = 16'd20000;
	localparam logic [REG_BITS-1:0] TIMEOUT_DISTANCE_RST = 16'd40000;

	// Control from the top level to every channel.
	typedef struct packed {
		logic clear;
		logic sample;
	} ept_chan_ctrl_t;

	// Status from a channel back to the top level.
	typedef struct packed {
		logic                 done;
		logic                 fin_timeout;
		logic [DIST_BITS-1:0] fin_dist;
	} ept_chan_stat_t;

	// Widen a counter value for comparison against a register.
	function automatic logic [CMP_BITS-1:0] ext_cnt(input logic [COUNT_BITS-1:0] v);
		return CMP_BITS'(v);
	endfunction

	// Widen a register value for comparison against the counter.
	function automatic logic [CMP_BITS-1:0] ext_reg(input logic [REG_BITS-1:0] v);
		return CMP_BITS'(v);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/ept_chan.sv -----
// State and next-state logic of one echo channel.
`default_nettype none

module ept_chan (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire ept_pkg::ept_chan_ctrl_t         ctrl,
	input  wire logic                            level,
	input  wire logic [ept_pkg::COUNT_BITS-1:0]  cnt,
	input  wire logic [ept_pkg::REG_BITS-1:0]    rise_deadline,
	input  wire logic [ept_pkg::REG_BITS-1:0]    fall_deadline,
	input  wire logic [ept_pkg::REG_BITS-1:0]    timeout_distance,
	output ept_pkg::ept_chan_stat_t              stat
);

	logic                              seen_q, done_q, to_q;
	logic [ept_pkg::COUNT_BITS-1:0]    rise_q;
	logic [ept_pkg::DIST_BITS-1:0]     width_q;

	logic                              seen_n, done_n, to_n;
	logic [ept_pkg::COUNT_BITS-1:0]    rise_n;
	logic [ept_pkg::DIST_BITS-1:0]     width_n;

	logic                              above_rise, above_fall;
	logic [ept_pkg::COUNT_BITS-1:0]    diff;
	logic [ept_pkg::CMP_BITS-1:0]      diff_ext;
	logic                              done_e, to_e;
	logic [ept_pkg::DIST_BITS-1:0]     width_e;

	// Deadline compares and the pulse width.
	assign above_rise = ept_pkg::ext_cnt(cnt) > ept_pkg::ext_reg(rise_deadline);
	assign above_fall = ept_pkg::ext_cnt(cnt) > ept_pkg::ext_reg(fall_deadline);
	assign diff       = rise_q - cnt;
	assign diff_ext   = ept_pkg::CMP_BITS'(diff);

	// Sample the echo level against the current count.
	always_comb begin
		seen_n  = seen_q;
		done_n  = done_q;
		to_n    = to_q;
		rise_n  = rise_q;
		width_n = width_q;
		if (!done_q) begin
			if (above_rise) begin
				if (level && !seen_q) begin
					seen_n = 1'b1;
					rise_n = cnt;
				end
			end else if (!seen_q) begin
				done_n  = 1'b1;
				seen_n  = 1'b0;
				to_n    = 1'b1;
				width_n = timeout_distance;
			end
			if (above_fall) begin
				if (!level && seen_n) begin
					seen_n  = 1'b0;
					width_n = diff_ext[ept_pkg::DIST_BITS-1:0];
					done_n  = 1'b1;
				end
			end else begin
				done_n  = 1'b1;
				seen_n  = 1'b0;
				to_n    = 1'b1;
				width_n = timeout_distance;
			end
		end
	end

	// Flags of the channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			done_q <= 1'b0;
			to_q   <= 1'b0;
		end else if (ctrl.clear) begin
			seen_q <= 1'b0;
			done_q <= 1'b0;
			to_q   <= 1'b0;
		end else if (ctrl.sample) begin
			seen_q <= seen_n;
			done_q <= done_n;
			to_q   <= to_n;
		end
	end

	// Rise time and width; only read once the matching flag is set.
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			rise_q  <= '0;
			width_q <= '0;
		end else if (ctrl.sample) begin
			rise_q  <= rise_n;
			width_q <= width_n;
		end
	end

	// Values the channel reports if the measurement ends with this item.
	assign done_e  = ctrl.sample ? done_n  : done_q;
	assign to_e    = ctrl.sample ? to_n    : to_q;
	assign width_e = ctrl.sample ? width_n : width_q;

	assign stat.done        = done_e;
	assign stat.fin_timeout = done_e ? to_e : 1'b1;
	assign stat.fin_dist    = done_e ? width_e : timeout_distance;

endmodule

`default_nettype wire

// ----- rtl/multi_channel_echo_pulse_timer_core.sv -----
// The input register and the result register are the two stages; a finishing tick passes both.
// Throughput: one item per cycle while the result register is not stalled.
// A stalled result holds the input register, and the block then stalls its input.
// Reset clears the control state, leaves the timer idle and loads the register defaults.
// The per-channel widths and rise times are cleared by each start item, not by reset.
`default_nettype none

module multi_channel_echo_pulse_timer_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [ept_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [ept_pkg::REG_BITS-1:0]       cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               opcode,
	input  wire logic [ept_pkg::ECHO_BITS-1:0]      echo,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [ept_pkg::DIST_BITS-1:0]           distance_0,
	output logic [ept_pkg::DIST_BITS-1:0]           distance_1,
	output logic [ept_pkg::DIST_BITS-1:0]           distance_2,
	output logic [ept_pkg::DIST_BITS-1:0]           distance_3,
	output logic [ept_pkg::OUT_CHANNELS-1:0]        timeout_mask
);

	logic [ept_pkg::REG_BITS-1:0]      start_count_q, rise_deadline_q;
	logic [ept_pkg::REG_BITS-1:0]      fall_deadline_q, timeout_distance_q;

	logic                              valid_s1, opcode_s1;
	logic [ept_pkg::ECHO_BITS-1:0]     echo_s1;

	logic [ept_pkg::COUNT_BITS-1:0]    countdown_q, count_dec, count_load;
	logic [ept_pkg::CMP_BITS-1:0]      load_ext;
	logic                              measuring_q;

	logic                              advance, is_start, tick_act, cnt_zero, all_done;
	logic                              finish, emit;
	ept_pkg::ept_chan_ctrl_t           chan_ctrl;
	ept_pkg::ept_chan_stat_t           chan_stat [ept_pkg::CHANNELS];
	logic [ept_pkg::CHANNELS-1:0]      done_vec;

	logic                              out_valid_q;
	logic [ept_pkg::DIST_BITS-1:0]     dist_q [ept_pkg::OUT_CHANNELS];
	logic [ept_pkg::OUT_CHANNELS-1:0]  mask_q;
	logic [ept_pkg::DIST_BITS-1:0]     dist_d [ept_pkg::OUT_CHANNELS];
	logic [ept_pkg::OUT_CHANNELS-1:0]  mask_d;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_count_q      <= ept_pkg::START_COUNT_RST;
			rise_deadline_q    <= ept_pkg::RISE_DEADLINE_RST;
			fall_deadline_q    <= ept_pkg::FALL_DEADLINE_RST;
			timeout_distance_q <= ept_pkg::TIMEOUT_DISTANCE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ept_pkg::REG_START_COUNT:      start_count_q      <= cfg_data;
				ept_pkg::REG_RISE_DEADLINE:    rise_deadline_q    <= cfg_data;
				ept_pkg::REG_FALL_DEADLINE:    fall_deadline_q    <= cfg_data;
				ept_pkg::REG_TIMEOUT_DISTANCE: timeout_distance_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The stage advances when the result register is free or being emptied.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			opcode_s1 <= opcode;
			echo_s1   <= echo;
		end
	end

	// Decode of the registered item.
	assign is_start  = valid_s1 && (opcode_s1 == ept_pkg::OP_START);
	assign tick_act  = valid_s1 && (opcode_s1 == ept_pkg::OP_TICK) && measuring_q;
	assign cnt_zero  = (countdown_q == '0);
	assign count_dec = countdown_q - 1'b1;
	assign load_ext  = ept_pkg::ext_reg(start_count_q);
	assign count_load = load_ext[ept_pkg::COUNT_BITS-1:0];

	assign chan_ctrl.clear  = advance && is_start;
	assign chan_ctrl.sample = advance && tick_act && !cnt_zero;

	// Channel units.
	for (genvar c = 0; c < ept_pkg::CHANNELS; c++) begin : g_chan
		logic lvl;
		if (c < ept_pkg::ECHO_BITS) begin : g_lvl
			assign lvl = echo_s1[c];
		end else begin : g_low
			assign lvl = 1'b0;
		end
		ept_chan u_chan (
			.clk              (clk),
			.arst_n           (arst_n),
			.ctrl             (chan_ctrl),
			.level            (lvl),
			.cnt              (countdown_q),
			.rise_deadline    (rise_deadline_q),
			.fall_deadline    (fall_deadline_q),
			.timeout_distance (timeout_distance_q),
			.stat             (chan_stat[c])
		);
		assign done_vec[c] = chan_stat[c].done;
	end

	// The measurement ends when all channels are done or the counter runs out.
	assign all_done = &done_vec;
	assign finish   = cnt_zero || all_done || (count_dec == '0);
	assign emit     = advance && tick_act && finish;

	// Counter and measurement flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			countdown_q <= '0;
			measuring_q <= 1'b0;
		end else if (advance) begin
			if (is_start) begin
				countdown_q <= count_load;
				measuring_q <= 1'b1;
			end else begin
				if (chan_ctrl.sample) begin
					countdown_q <= count_dec;
				end
				if (emit) begin
					measuring_q <= 1'b0;
				end
			end
		end
	end

	// Result fields; channels that are not built report zero.
	for (genvar o = 0; o < ept_pkg::OUT_CHANNELS; o++) begin : g_out
		if (o < ept_pkg::CHANNELS) begin : g_live
			assign dist_d[o] = chan_stat[o].fin_dist;
			assign mask_d[o] = chan_stat[o].fin_timeout;
		end else begin : g_none
			assign dist_d[o] = '0;
			assign mask_d[o] = 1'b0;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			dist_q <= dist_d;
			mask_q <= mask_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign distance_0   = dist_q[0];
	assign distance_1   = dist_q[1];
	assign distance_2   = dist_q[2];
	assign distance_3   = dist_q[3];
	assign timeout_mask = mask_q;

	// A result always closes the measurement.
	a_emit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> !measuring_q)
		else $error("measurement still open after a result");

	// An idle timer never produces a result.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!measuring_q |-> !emit)
		else $error("result produced while idle");

	// A start item loads the counter and opens a measurement.
	a_start_load: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && is_start) |=> (measuring_q && countdown_q == $past(count_load)))
		else $error("start item did not load the counter");

	// A sampled tick steps the counter down by one.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(chan_ctrl.sample) |=> (countdown_q == $past(count_dec)))
		else $error("counter did not step down by one");

endmodule

`default_nettype wire

// ----- tb/echo_width_checker.sv -----
// Checker for the echo pulse timer: predicts every result and compares it with the block's output.
module echo_width_checker
	import ept_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [REG_BITS-1:0]     cfg_data,
	input  wire logic                    in_valid,
	input  wire logic                    in_stall,
	input  wire logic                    opcode,
	input  wire logic [ECHO_BITS-1:0]    echo,
	input  wire logic                    out_valid,
	input  wire logic                    out_stall,
	input  wire logic [DIST_BITS-1:0]    distance_0,
	input  wire logic [DIST_BITS-1:0]    distance_1,
	input  wire logic [DIST_BITS-1:0]    distance_2,
	input  wire logic [DIST_BITS-1:0]    distance_3,
	input  wire logic [OUT_CHANNELS-1:0] timeout_mask,
	output int                           fail_count,
	output int                           widths_owed,
	output logic                         timer_open
);

	// One finished measurement as it leaves the block.
	typedef struct packed {
		logic [OUT_CHANNELS-1:0][DIST_BITS-1:0] dists;
		logic [OUT_CHANNELS-1:0]                mask;
	} echo_result_t;

	// Register copies.
	logic [REG_BITS-1:0] load_count   = START_COUNT_RST;
	logic [REG_BITS-1:0] rise_limit   = RISE_DEADLINE_RST;
	logic [REG_BITS-1:0] fall_limit   = FALL_DEADLINE_RST;
	logic [REG_BITS-1:0] timeout_dist = TIMEOUT_DISTANCE_RST;

	// Timer and per-channel state.
	logic [COUNT_BITS-1:0] ticks_left = '0;
	logic                  running    = 1'b0;
	logic [CHANNELS-1:0]   echo_high  = '0;
	logic [CHANNELS-1:0]   finished   = '0;
	logic [CHANNELS-1:0]   flagged    = '0;
	logic [COUNT_BITS-1:0] rise_stamp  [CHANNELS];
	logic [DIST_BITS-1:0]  pulse_width [CHANNELS];

	echo_result_t expected_widths [$];
	echo_result_t seen_widths;
	echo_result_t due_widths;
	logic         made_result;

	assign widths_owed = expected_widths.size();
	assign timer_open  = running;

	// A start item clears every channel.
	task automatic wipe_channels();
		echo_high = '0;
		finished  = '0;
		flagged   = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			rise_stamp[c]  = '0;
			pulse_width[c] = '0;
		end
	endtask

	// A channel that missed a deadline reports the timeout distance.
	task automatic close_channel(input int c);
		finished[c]    = 1'b1;
		echo_high[c]   = 1'b0;
		flagged[c]     = 1'b1;
		pulse_width[c] = DIST_BITS'(timeout_dist);
	endtask

	// Works out what one accepted item does to the timer and whether it ends a measurement.
	task automatic compute_echo_widths(input logic op, input logic [ECHO_BITS-1:0] lines,
			output logic made, output echo_result_t widths);
		logic wrap_up;
		logic lvl;
		wrap_up = 1'b0;
		widths  = '0;
		if (op == OP_START) begin
			ticks_left = COUNT_BITS'(load_count);
			wipe_channels();
			running = 1'b1;
		end else if (running) begin
			if (ticks_left == '0) begin
				// The counter was loaded with zero: finish without sampling.
				wrap_up = 1'b1;
			end else begin
				for (int c = 0; c < CHANNELS; c++) begin
					lvl = (c < ECHO_BITS) ? lines[c] : 1'b0;
					if (!finished[c]) begin
						if (ticks_left > rise_limit) begin
							if (lvl && !echo_high[c]) begin
								echo_high[c]  = 1'b1;
								rise_stamp[c] = ticks_left;
							end
						end else if (!echo_high[c]) begin
							close_channel(c);
						end
						if (ticks_left > fall_limit) begin
							if (!lvl && echo_high[c]) begin
								echo_high[c]   = 1'b0;
								pulse_width[c] = DIST_BITS'(rise_stamp[c] - ticks_left);
								finished[c]    = 1'b1;
							end
						end else begin
							close_channel(c);
						end
					end
				end
				ticks_left = ticks_left - 1'b1;
				wrap_up = (&finished) || (ticks_left == '0);
			end
		end
		if (wrap_up) begin
			// Channels still open at the end time out.
			for (int c = 0; c < CHANNELS; c++) begin
				if (!finished[c])
					close_channel(c);
				if (c < OUT_CHANNELS) begin
					widths.dists[c] = pulse_width[c];
					widths.mask[c]  = flagged[c];
				end
			end
			running = 1'b0;
		end
		made = wrap_up;
	endtask

	// Compare results first, then follow register writes and new items.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count   = START_COUNT_RST;
			rise_limit   = RISE_DEADLINE_RST;
			fall_limit   = FALL_DEADLINE_RST;
			timeout_dist = TIMEOUT_DISTANCE_RST;
			ticks_left   = '0;
			running      = 1'b0;
			wipe_channels();
			expected_widths.delete();
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen_widths.dists = {distance_3, distance_2, distance_1, distance_0};
				seen_widths.mask  = timeout_mask;
				if (expected_widths.size() == 0) begin
					$error("result with no measurement pending: distances %0d %0d %0d %0d, mask %h",
						distance_0, distance_1, distance_2, distance_3, timeout_mask);
					fail_count++;
				end else begin
					due_widths = expected_widths.pop_front();
					for (int c = 0; c < OUT_CHANNELS; c++) begin
						if (seen_widths.dists[c] !== due_widths.dists[c]) begin
							$error("distance_%0d: expected %0d, got %0d",
								c, due_widths.dists[c], seen_widths.dists[c]);
							fail_count++;
						end
					end
					if (seen_widths.mask !== due_widths.mask) begin
						$error("timeout_mask: expected %h, got %h",
							due_widths.mask, seen_widths.mask);
						fail_count++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_START_COUNT:      load_count   = cfg_data;
					REG_RISE_DEADLINE:    rise_limit   = cfg_data;
					REG_FALL_DEADLINE:    fall_limit   = cfg_data;
					REG_TIMEOUT_DISTANCE: timeout_dist = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				compute_echo_widths(opcode, echo, made_result, due_widths);
				if (made_result)
					expected_widths.push_back(due_widths);
			end
		end
	end

endmodule

// ----- tb/multi_channel_echo_pulse_timer_core_test.sv -----
// Top of the echo pulse timer test: clock, reset, stimulus, result draining and the verdict.
module multi_channel_echo_pulse_timer_core_test;
	import ept_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int RESULT_LAG  = 4;
	localparam int ITEM_BUDGET = 1750;
	localparam int PHASE_ITEMS = 220;
	localparam int NEVER       = 1 << 30;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    cfg_we    = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = REG_START_COUNT;
	logic [REG_BITS-1:0]     cfg_data  = '0;
	logic                    in_valid  = 1'b0;
	logic                    opcode    = OP_START;
	logic [ECHO_BITS-1:0]    echo      = '0;
	logic                    out_stall = 1'b0;
	logic                    in_stall;
	logic                    out_valid;
	logic [DIST_BITS-1:0]    distance_0;
	logic [DIST_BITS-1:0]    distance_1;
	logic [DIST_BITS-1:0]    distance_2;
	logic [DIST_BITS-1:0]    distance_3;
	logic [OUT_CHANNELS-1:0] timeout_mask;

	int   fail_count;
	int   widths_owed;
	logic timer_open;
	int   quiet = 0;
	bit   calm  = 1'b0;

	// Register values the stimulus is shaped for.
	int now_start = START_COUNT_RST;
	int now_rise  = RISE_DEADLINE_RST;
	int now_fall  = FALL_DEADLINE_RST;

	multi_channel_echo_pulse_timer_core DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .echo(echo),
		.out_valid(out_valid), .out_stall(out_stall),
		.distance_0(distance_0), .distance_1(distance_1),
		.distance_2(distance_2), .distance_3(distance_3),
		.timeout_mask(timeout_mask)
	);

	echo_width_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .echo(echo),
		.out_valid(out_valid), .out_stall(out_stall),
		.distance_0(distance_0), .distance_1(distance_1),
		.distance_2(distance_2), .distance_3(distance_3),
		.timeout_mask(timeout_mask),
		.fail_count(fail_count), .widths_owed(widths_owed), .timer_open(timer_open)
	);

	// Clock with a period of 12.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Results are taken after a random hold for each one.
	always begin : result_drain
		int hold;
		hold = calm ? 0 : $urandom_range(12);
		if (hold > 0) begin
			out_stall <= 1'b1;
			repeat (hold) @(posedge clk);
		end
		out_stall <= 1'b0;
		do @(posedge clk); while (!(arst_n && out_valid));
	end

	// Ends the run when neither channel has moved for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("multi_channel_echo_pulse_timer_core_test NOT OK");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// Offers one item after a random gap and holds it until it is taken.
	task automatic send_item(input logic op, input logic [ECHO_BITS-1:0] lines);
		int gap;
		gap = calm ? 0 : $urandom_range(12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		echo     <= lines;
		do @(posedge clk); while (in_stall);
	endtask

	// Waits until every predicted result has been taken, then lets the pipeline empty.
	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (widths_owed != 0);
		repeat (RESULT_LAG) @(posedge clk);
	endtask

	// Finishes any open measurement so that the registers can be changed safely.
	task automatic close_out();
		settle();
		while (timer_open) begin
			send_item(OP_TICK, '1);
			send_item(OP_TICK, '0);
			settle();
		end
	endtask

	// Writes all four registers, one per cycle.
	task automatic load_registers(input int s, input int r, input int f, input int t);
		close_out();
		cfg_we    <= 1'b1;
		cfg_index <= REG_START_COUNT;
		cfg_data  <= REG_BITS'(s);
		@(posedge clk);
		cfg_index <= REG_RISE_DEADLINE;
		cfg_data  <= REG_BITS'(r);
		@(posedge clk);
		cfg_index <= REG_FALL_DEADLINE;
		cfg_data  <= REG_BITS'(f);
		@(posedge clk);
		cfg_index <= REG_TIMEOUT_DISTANCE;
		cfg_data  <= REG_BITS'(t);
		@(posedge clk);
		cfg_we    <= 1'b0;
		now_start = s;
		now_rise  = r;
		now_fall  = f;
	endtask

	// One measurement: a start, then echo pulses that mostly meet the deadlines.
	task automatic run_measurement(output int counted);
		int span_rise;
		int span_fall;
		int stop_at;
		int n_ticks;
		int rise_at [CHANNELS];
		int fall_at [CHANNELS];
		logic [ECHO_BITS-1:0] lines;
		span_rise = (now_start > now_rise) ? now_start - now_rise : 0;
		span_fall = (now_start > now_fall) ? now_start - now_fall : 0;
		stop_at = 0;
		for (int c = 0; c < CHANNELS; c++) begin
			if (span_rise <= 40 && $urandom_range(5) == 0) begin
				// A silent channel waits out the rise deadline.
				rise_at[c] = NEVER;
				fall_at[c] = NEVER;
				if (span_rise > stop_at)
					stop_at = span_rise;
			end else begin
				rise_at[c] = $urandom_range(0, (span_rise < 20) ? span_rise : 20);
				fall_at[c] = rise_at[c] + 1 + $urandom_range(0, (span_fall < 30) ? span_fall : 30);
				if (fall_at[c] > stop_at)
					stop_at = fall_at[c];
			end
		end
		n_ticks = stop_at + 2;
		if (n_ticks > now_start + 1)
			n_ticks = now_start + 1;
		if (n_ticks > span_fall + 2)
			n_ticks = span_fall + 2;
		// Now and then the measurement is abandoned and restarted by the next start.
		if ($urandom_range(11) == 0)
			n_ticks = $urandom_range(0, n_ticks);
		send_item(OP_START, ECHO_BITS'($urandom));
		for (int k = 0; k < n_ticks; k++) begin
			for (int c = 0; c < ECHO_BITS; c++)
				lines[c] = (k >= rise_at[c]) && (k < fall_at[c]);
			if ($urandom_range(39) == 0)
				lines[$urandom_range(ECHO_BITS - 1)] ^= 1'b1;
			send_item(OP_TICK, lines);
		end
		counted = n_ticks + 1;
	endtask

	initial begin : stimulus
		int counted;
		int used;
		int in_phase;
		int phase;
		int s;
		int r;
		int f;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults: an idle tick, an ordinary measurement, a restart.
		send_item(OP_TICK, 4'hF);
		send_item(OP_START, 4'h0);
		send_item(OP_TICK, 4'hF);
		send_item(OP_TICK, 4'hA);
		send_item(OP_TICK, 4'h0);
		send_item(OP_START, 4'hF);
		send_item(OP_TICK, 4'h5);
		send_item(OP_START, 4'h0);
		send_item(OP_TICK, 4'hF);
		send_item(OP_TICK, 4'h0);

		// Largest count with deadlines one and two ticks away.
		load_registers(65535, 65534, 65533, 0);
		send_item(OP_START, 4'h0);
		send_item(OP_TICK, 4'hF);
		send_item(OP_TICK, 4'h0);
		send_item(OP_START, 4'h0);
		send_item(OP_TICK, 4'h5);
		send_item(OP_TICK, 4'h5);
		send_item(OP_TICK, 4'h5);

		// A zero start count finishes at the first tick; the next tick is ignored.
		load_registers(0, 0, 0, 65535);
		send_item(OP_START, 4'hF);
		send_item(OP_TICK, 4'hF);
		send_item(OP_TICK, 4'hF);

		// Both deadlines pass in the same tick.
		load_registers(3, 2, 2, 16'h5A5A);
		send_item(OP_START, 4'h0);
		send_item(OP_TICK, 4'h1);
		send_item(OP_TICK, 4'h0);

		// The counter runs out with channels still open.
		load_registers(2, 0, 0, 16'hA5A5);
		send_item(OP_START, 4'h0);
		send_item(OP_TICK, 4'h3);
		send_item(OP_TICK, 4'h2);

		// Random measurements over a series of register settings.
		counted = 0;
		phase = 0;
		while (counted < ITEM_BUDGET) begin
			case (phase)
				0: load_registers(START_COUNT_RST, RISE_DEADLINE_RST, FALL_DEADLINE_RST,
					TIMEOUT_DISTANCE_RST);
				1: load_registers(65535, 65535, 65535, 65535);
				2: load_registers(65535, 65530, 65500, $urandom_range(65535));
				3: load_registers(40, 0, 0, $urandom_range(65535));
				default: begin
					s = $urandom_range(1, 80);
					r = $urandom_range(0, s + 4);
					f = ($urandom_range(3) == 0) ? r : $urandom_range(0, s + 4);
					load_registers(s, r, f, $urandom_range(65535));
				end
			endcase
			calm = ($urandom_range(2) == 0);
			in_phase = 0;
			while (in_phase < PHASE_ITEMS) begin
				if ($urandom_range(14) == 0)
					settle();
				if ($urandom_range(9) == 0)
					repeat ($urandom_range(1, 3))
						send_item(1'($urandom_range(1)), ECHO_BITS'($urandom));
				run_measurement(used);
				in_phase += used;
			end
			counted += in_phase;
			phase++;
		end
		calm = 1'b0;
		settle();

		if (fail_count == 0) begin
			$display("multi_channel_echo_pulse_timer_core_test OK");
		end else begin
			$display("multi_channel_echo_pulse_timer_core_test NOT OK");
		end
		$finish;
	end

endmodule
